// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define HWLU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Checked on every rising clock edge, reset included.
`define HWLU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- design/hwlu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hwlu_pkg;

  // Command codes on the request channel
  typedef enum logic [1:0] {
    CMD_PICK      = 2'd0,
    CMD_COMPLETED = 2'd1,
    CMD_FAILED    = 2'd2
  } cmd_e;

  localparam int CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS:0] HEALTH_WINDOW = 17'd10;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] backend_index;
  } req_item_t;

  typedef struct packed {
    logic [3:0]  chosen_backend;
    logic [1:0]  chosen_health;
    logic [31:0] chosen_weight;
  } rsp_item_t;

  // One status memory entry
  typedef struct packed {
    logic [1:0]            health;
    logic [COUNT_BITS-1:0] completed;
    logic [COUNT_BITS-1:0] failed;
  } stat_t;

  // Control into the minimum scan unit
  typedef struct packed {
    logic sample;
    logic first;
  } scan_ctl_t;

  // Weight step for a health level
  function automatic logic [6:0] weight_step(input logic [1:0] level);
    logic [6:0] step;
    case (level)
      2'd0:    step = 7'd1;
      2'd1:    step = 7'd2;
      2'd2:    step = 7'd8;
      default: step = 7'd64;
    endcase
    return step;
  endfunction

  // Saturating counter increment
  function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Health level step; counters clear on level change or window expiry
  function automatic stat_t health_eval(input stat_t s);
    stat_t               r;
    logic [COUNT_BITS:0] sum;
    logic                fire;
    r    = s;
    sum  = {1'b0, s.completed} + {1'b0, s.failed};
    fire = 1'b0;
    case (s.health)
      2'd0: begin
        if (s.failed != '0) begin
          r.health = 2'd1;
          fire     = 1'b1;
        end
      end
      2'd1: begin
        if (sum > HEALTH_WINDOW) begin
          fire = 1'b1;
          if (s.failed > s.completed) r.health = 2'd2;
          else if (s.failed == '0) r.health = 2'd0;
        end
      end
      2'd2: begin
        if (sum > HEALTH_WINDOW) begin
          fire = 1'b1;
          if (s.completed == '0) r.health = 2'd3;
          else if (s.completed > s.failed) r.health = 2'd1;
        end
      end
      default: begin
        if (s.completed != '0) begin
          r.health = 2'd2;
          fire     = 1'b1;
        end
      end
    endcase
    if (fire) begin
      r.completed = '0;
      r.failed    = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/hwlu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module hwlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/hwlu_min_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Running minimum over weights streamed from memory; lowest index wins ties
module hwlu_min_scan import hwlu_pkg::*; #(
  parameter int IW = 4,
  parameter int WB = 32
) (
  input  wire logic      clk,
  input  wire scan_ctl_t ctl,
  input  wire logic [IW-1:0] idx,
  input  wire logic [WB-1:0] weight,
  output logic [IW-1:0]  best_idx,
  output logic [WB-1:0]  best_weight
);

  // strict less-than keeps the earlier index on ties
  always_ff @(posedge clk) begin
    if (ctl.sample && (ctl.first || weight < best_weight)) begin
      best_idx    <= idx;
      best_weight <= weight;
    end
  end

endmodule

`default_nettype wire

// ----- design/health_weighted_least_used_picker.sv -----
// Health-weighted least-used backend picker.
// Request channel (req_valid/req_stall/req): one command per transaction.
// A pick returns one response transaction on rsp_valid/rsp_stall/rsp; a
// completed or failed event only bumps that backend's counter.
// Configuration: cfg_we writes cfg_wdata (backends in use); the user must
// write it only while idle, which the block does not enforce. A pick
// reads the weight memory once per backend in use, one per cycle, then
// the status entry of the winner is read, updated and written back
// together with its weight as the response is loaded. Completed/failed
// events read, modify and write the status memory; an unused command is
// taken and dropped without making the block busy.
// One item is in flight at a time; req_stall is high while it is.
// A finished response sits in the output register; while rsp_stall holds
// it, new requests are still taken, and a following pick waits in its
// update step until the register frees.
// Reset (synchronous) returns all weights to 1, health and counters to 0
// through per-entry valid bits, sets backends in use to 16, and drops any
// pending response.
`timescale 1ns / 1ps
`default_nettype none

module health_weighted_least_used_picker import hwlu_pkg::*; #(
  parameter int MAX_BACKENDS = 16,
  parameter int WEIGHT_BITS  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire req_item_t           req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output rsp_item_t                rsp,
  input  wire logic                cfg_we,
  input  wire logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_BACKENDS);
  localparam int WB = WEIGHT_BITS;
  localparam int SB = $bits(stat_t);
  localparam logic [8:0] MAXN = 9'(MAX_BACKENDS);

  typedef enum logic [2:0] {
    S_IDLE, S_CNT_RD, S_CNT_WR, S_SCAN, S_LAST, S_STAT_RD, S_UPD
  } state_t;

  state_t              state;
  logic [CFG_BITS-1:0] cfg;
  logic [IW-1:0]       ev_idx;
  logic                ev_fail;
  logic [IW-1:0]       scan_idx;
  logic [IW-1:0]       last_idx;
  logic                smp;
  logic                smp_first;
  logic [IW-1:0]       smp_idx;
  logic [MAX_BACKENDS-1:0] wt_vld;
  logic [MAX_BACKENDS-1:0] st_vld;
  logic                w_rd_vld;
  logic                s_rd_vld;

  logic            accept;
  logic            out_free;
  logic [8:0]      n_cfg;
  logic [IW-1:0]   last_cfg;
  logic            idx_ok;
  logic            w_we;
  logic [WB-1:0]   w_rdata;
  logic [WB-1:0]   w_wdata;
  logic            s_we;
  logic [IW-1:0]   s_raddr;
  logic [SB-1:0]   s_rdata;
  logic [SB-1:0]   s_wdata;
  stat_t           st_cur;
  stat_t           st_upd;
  stat_t           st_cnt;
  scan_ctl_t       scan_ctl;
  logic [WB-1:0]   scan_w;
  logic [IW-1:0]   best_idx;
  logic [WB-1:0]   best_w;
  logic [WB-1:0]   inc_w;
  logic [WB-1:0]   max_w;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Clamp backends in use to 1..MAX_BACKENDS and turn it into a last index
  always_comb begin
    n_cfg = 9'(cfg);
    if (n_cfg == '0) begin
      last_cfg = '0;
    end else if (n_cfg > MAXN) begin
      last_cfg = IW'(MAX_BACKENDS - 1);
    end else begin
      last_cfg = IW'(n_cfg - 9'd1);
    end
  end

  assign idx_ok = (9'(req.backend_index) < MAXN);

  // Status entry: invalid entries read as the reset value
  assign s_raddr = (state == S_CNT_RD || state == S_CNT_WR) ? ev_idx : best_idx;
  assign st_cur  = s_rd_vld ? stat_t'(s_rdata) : stat_t'('0);

  // Counter event
  always_comb begin
    st_cnt = st_cur;
    if (ev_fail) begin
      st_cnt.failed = count_inc(st_cur.failed);
    end else begin
      st_cnt.completed = count_inc(st_cur.completed);
    end
  end

  // Pick update: health first, then weight step by new level
  assign st_upd = health_eval(st_cur);
  assign inc_w  = WB'(weight_step(st_upd.health));
  assign max_w  = '1;
  assign w_wdata = (best_w > max_w - inc_w) ? max_w : best_w + inc_w;

  assign w_we    = (state == S_UPD) && out_free;
  assign s_we    = w_we || (state == S_CNT_WR);
  assign s_wdata = (state == S_CNT_WR) ? SB'(st_cnt) : SB'(st_upd);

  // Memories
  hwlu_ram #(.WIDTH(WB), .DEPTH(MAX_BACKENDS)) u_wt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (best_idx),
    .wdata (w_wdata),
    .raddr (scan_idx),
    .rdata (w_rdata)
  );

  hwlu_ram #(.WIDTH(SB), .DEPTH(MAX_BACKENDS)) u_st_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_raddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Minimum scan over the weight stream
  assign scan_ctl.sample = smp;
  assign scan_ctl.first  = smp_first;
  assign scan_w = w_rd_vld ? w_rdata : WB'(1);

  hwlu_min_scan #(.IW(IW), .WB(WB)) u_scan (
    .clk         (clk),
    .ctl         (scan_ctl),
    .idx         (smp_idx),
    .weight      (scan_w),
    .best_idx    (best_idx),
    .best_weight (best_w)
  );

  // Valid bits and their registered read copies
  always_ff @(posedge clk) begin
    w_rd_vld <= wt_vld[scan_idx];
    s_rd_vld <= st_vld[s_raddr];
    if (rst) begin
      wt_vld <= '0;
      st_vld <= '0;
    end else begin
      if (w_we) wt_vld[best_idx] <= 1'b1;
      if (s_we) st_vld[s_raddr]  <= 1'b1;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      cfg <= cfg_wdata;
    end
  end

  // Sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      smp       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // the update step reloads the register itself when it frees
      if (rsp_valid && !rsp_stall && state != S_UPD) rsp_valid <= 1'b0;
      smp <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ev_idx   <= IW'(req.backend_index);
            ev_fail  <= (req.command == CMD_FAILED);
            scan_idx <= '0;
            last_idx <= last_cfg;
            if (req.command == CMD_PICK) begin
              state <= S_SCAN;
            end else if ((req.command == CMD_COMPLETED || req.command == CMD_FAILED)
                         && idx_ok) begin
              state <= S_CNT_RD;
            end
          end
        end
        S_CNT_RD: state <= S_CNT_WR;
        S_CNT_WR: state <= S_IDLE;
        S_SCAN: begin
          smp_idx   <= scan_idx;
          smp_first <= (scan_idx == '0);
          if (scan_idx == last_idx) begin
            state <= S_LAST;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_LAST:    state <= S_STAT_RD;
        S_STAT_RD: state <= S_UPD;
        S_UPD: begin
          if (out_free) begin
            rsp_valid          <= 1'b1;
            rsp.chosen_backend <= 4'(best_idx);
            rsp.chosen_health  <= st_upd.health;
            rsp.chosen_weight  <= 32'(w_wdata);
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/hwlu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Port-level checks for the picker
module hwlu_checker import hwlu_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      req_valid,
  input wire logic      req_stall,
  input wire req_item_t req,
  input wire logic      rsp_valid,
  input wire logic      rsp_stall,
  input wire rsp_item_t rsp
);

  // a held response keeps its contents
  `HWLU_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

  // any real command keeps the block busy for the next cycle
  `HWLU_ASSERT(a_busy_after_cmd, clk, rst, req_valid && !req_stall && (req.command == CMD_PICK || req.command == CMD_COMPLETED || req.command == CMD_FAILED) |=> req_stall)

  // a chosen weight is at least its start value plus one step
  `HWLU_ASSERT(a_weight_grown, clk, rst, rsp_valid |-> rsp.chosen_weight >= 32'd2)

  // reset drops any pending response
  `HWLU_ASSERT_ALWAYS(a_rst_clears, clk, rst |=> !rsp_valid)

endmodule

bind health_weighted_least_used_picker hwlu_checker u_hwlu_checker (.*);

`default_nettype wire
